// ----- hw/rtl/stks_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stks_pkg: shared types and constants of the streaming top-k selector
// Field structs for the score stream and ranked results, store sizes.
// ----------------------------------------------------------------------------
package stks_pkg;

   localparam int KMax       = 8;
   localparam int MaxLen     = 131072;
   localparam int KW         = 4;    // keep_count width
   localparam int PosW       = 18;   // position counter width
   localparam int IdxW       = 17;
   localparam int SlotW      = $clog2(KMax);
   localparam logic [KW-1:0] KeepReset = KW'(5);

   typedef struct packed {
      logic [31:0] score_bits;
      logic        stream_end;
   } req_type;

   typedef struct packed {
      logic [IdxW-1:0] rank_index;
      logic [31:0]     rank_score;
      logic            run_last;
   } rsp_type;

   // Map a float pattern to an unsigned key with the same order.
   function automatic logic [31:0] order_key(input logic [31:0] b);
      order_key = b[31] ? ~b : {1'b0, b[30:0]} | 32'h8000_0000;
   endfunction

endpackage

// ----- hw/rtl/streaming_top_k_select.sv -----
`timescale 1ns / 1ps
// The store updates on the edge that accepts a beat; a report starts on the
// cycle after its last beat, sends one result beat per cycle while rsp_ready
// is high, from a buffer. Throughput: one score per cycle; scores keep flowing
// while a report drains, only a last beat waits until the previous one drains.
// Reset: synchronous; store empty, position 0, keep_count 5.
// ----------------------------------------------------------------------------
// streaming_top_k_select
// Keeps the k largest float scores with positions in a sorted register store
// and reports them highest first on the last beat of each vector.
// ----------------------------------------------------------------------------
module streaming_top_k_select
   import stks_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   input  logic            csr_we,
   input  logic [KW-1:0]   csr_wdata
);

   logic [KW-1:0]   keep_ff;
   logic [31:0]     sc_ff  [KMax];
   logic [IdxW-1:0] ix_ff  [KMax];
   logic [KW-1:0]   fill_ff, fill_in;
   logic [PosW-1:0] pos_ff;
   // report buffer: snapshot of the store being drained
   logic [31:0]     rs_ff  [KMax];
   logic [IdxW-1:0] ri_ff  [KMax];
   logic [KW-1:0]   rcnt_ff;   // entries left to send
   logic [SlotW-1:0] rptr_ff;

   logic            acc;
   logic [KW-1:0]   k_sat, fill_cut;
   logic [31:0]     key_new;
   logic [KMax-1:0] ge;        // entry i stays above new score
   logic [31:0]     sc_in [KMax];
   logic [IdxW-1:0] ix_in [KMax];
   logic            take;

   assign k_sat    = (keep_ff > KW'(KMax)) ? KW'(KMax) : keep_ff;
   assign fill_cut = (fill_ff > k_sat) ? k_sat : fill_ff;
   // only a last beat has to wait for the report buffer
   assign req_ready = (rcnt_ff == '0) || !req_data.stream_end;
   assign acc      = req_valid && req_ready;
   assign key_new  = order_key(req_data.score_bits);
   assign take     = (pos_ff < PosW'(MaxLen)) && (k_sat != '0);

   // Build the shifted store: slot i keeps, takes the new item, or shifts down.
   always_comb begin
      fill_in = fill_cut;
      for (int i = 0; i < KMax; i++) begin
         ge[i] = (KW'(i) < fill_cut) && (order_key(sc_ff[i]) >= key_new);
      end
      for (int i = 0; i < KMax; i++) begin
         sc_in[i] = sc_ff[i];
         ix_in[i] = ix_ff[i];
         if (take && KW'(i) < k_sat && !ge[i]) begin
            if (i == 0 || ge[(i == 0) ? 0 : i-1]) begin
               sc_in[i] = req_data.score_bits;
               ix_in[i] = pos_ff[IdxW-1:0];
            end else begin
               sc_in[i] = sc_ff[(i == 0) ? 0 : i-1];
               ix_in[i] = ix_ff[(i == 0) ? 0 : i-1];
            end
         end
      end
      if (take && fill_cut < k_sat) fill_in = fill_cut + KW'(1);
   end

   // Hold the control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= KeepReset;
         fill_ff <= '0;
         pos_ff  <= '0;
         rcnt_ff <= '0;
         rptr_ff <= '0;
      end else begin
         if (csr_we) keep_ff <= csr_wdata;
         if (acc) begin
            if (req_data.stream_end) begin
               fill_ff <= '0;
               pos_ff  <= '0;
            end else begin
               fill_ff <= fill_in;
               if (pos_ff < PosW'(MaxLen)) pos_ff <= pos_ff + PosW'(1);
            end
         end
         // load a new report, or advance the one draining
         if (acc && req_data.stream_end) begin
            rcnt_ff <= fill_in;
            rptr_ff <= '0;
         end else if (rsp_valid && rsp_ready) begin
            rcnt_ff <= rcnt_ff - KW'(1);
            rptr_ff <= rptr_ff + SlotW'(1);
         end
      end
   end

   // Advance the store and snapshot it on a last beat.
   always_ff @(posedge clock) begin
      if (acc) begin
         for (int i = 0; i < KMax; i++) begin
            sc_ff[i] <= sc_in[i];
            ix_ff[i] <= ix_in[i];
            if (req_data.stream_end) begin
               rs_ff[i] <= sc_in[i];
               ri_ff[i] <= ix_in[i];
            end
         end
      end
   end

   assign rsp_valid          = (rcnt_ff != '0);
   assign rsp_data.rank_index = ri_ff[rptr_ff];
   assign rsp_data.rank_score = rs_ff[rptr_ff];
   assign rsp_data.run_last   = (rcnt_ff == KW'(1));

endmodule

// ----- hw/rtl/stks_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stks_checker: port-level checks of the top-k selector
// Watches handshakes and report framing.
// ----------------------------------------------------------------------------
module stks_checker
   import stks_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped while stalled");

   // no new last beat while a report drains
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && req_valid && req_data.stream_end |-> !req_ready)
      else $error("last beat taken during report");

   // after the final beat the report ends
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.run_last |=> !rsp_valid)
      else $error("report continues past last");

endmodule

bind streaming_top_k_select stks_checker u_stks_checker (.*);

// ----- verif/streaming_top_k_select_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_top_k_select_tb: regression bench for the streaming top-k selector
// Drives score vectors with random gaps, ranks them in a local model of the
// sorted store, and checks each reported entry in order against the model.
// ----------------------------------------------------------------------------
module streaming_top_k_select_tb;
   import stks_pkg::*;

   localparam int WatchLimit = 5000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we = 1'b0;
   logic [KW-1:0] csr_wdata = '0;

   // ranking model state
   logic [31:0]     mdl_scores [KMax];
   logic [IdxW-1:0] mdl_index  [KMax];
   int              mdl_filled;
   int              mdl_pos;
   int              mdl_keep;
   rsp_type         ranked_q [$];
   int              errors = 0;
   int              idle_cycles = 0;

   streaming_top_k_select DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] rank_key(input logic [31:0] b);
      return b[31] ? ~b : (b ^ 32'h8000_0000);
   endfunction

   // Advance the model by one score and queue any report it causes.
   task automatic rank_score(input logic [31:0] bits, input logic last);
      int k;
      int ins;
      int top;
      rsp_type r;
      k = (mdl_keep > KMax) ? KMax : mdl_keep;
      if (mdl_filled > k) mdl_filled = k;
      if (mdl_pos < MaxLen) begin
         if (k != 0) begin
            ins = 0;
            while (ins < mdl_filled && rank_key(mdl_scores[ins]) >= rank_key(bits))
               ins++;
            if (ins < k) begin
               top = (mdl_filled < k) ? mdl_filled : k - 1;
               for (int i = top; i > ins; i--) begin
                  mdl_scores[i] = mdl_scores[i-1];
                  mdl_index[i]  = mdl_index[i-1];
               end
               mdl_scores[ins] = bits;
               mdl_index[ins]  = mdl_pos[IdxW-1:0];
               if (mdl_filled < k) mdl_filled++;
            end
         end
         mdl_pos++;
      end
      if (last) begin
         for (int i = 0; i < mdl_filled; i++) begin
            r.rank_index = mdl_index[i];
            r.rank_score = mdl_scores[i];
            r.run_last   = (i + 1 == mdl_filled);
            ranked_q.insert(ranked_q.size(), r);
         end
         mdl_filled = 0;
         mdl_pos = 0;
      end
   endtask

   // Send one score beat after a random gap; valid stays up into the next beat.
   task automatic send_score(input logic [31:0] bits, input logic last);
      int gap;
      gap = $urandom_range(0, 15);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{score_bits: bits, stream_end: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rank_score(bits, last);
   endtask

   // Drop valid and wait until every expected result is in.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ranked_q.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // Write keep_count while idle.
   task automatic set_keep(input int k);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= KW'(k);
      @(negedge clock);
      csr_we <= 1'b0;
      mdl_keep = k;
   endtask

   function automatic logic [31:0] rand_score();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom)};
         3: return 32'h3F80_0000 + $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_vector(input int len);
      for (int i = 0; i < len; i++) send_score(rand_score(), i == len - 1);
   endtask

   // Extremes, signed zeros, NaNs, ties, single-item vector.
   task automatic test_directed();
      send_score(32'h0000_0000, 1'b0);
      send_score(32'h8000_0000, 1'b0);
      send_score(32'hFFFF_FFFF, 1'b0);
      send_score(32'h7FFF_FFFF, 1'b0);
      send_score(32'h7F80_0000, 1'b0);
      send_score(32'hFF80_0000, 1'b0);
      send_score(32'h3F80_0000, 1'b0);
      send_score(32'h3F80_0000, 1'b1);
      send_score(32'hAAAA_5555, 1'b1);
      send_score(32'h5555_AAAA, 1'b0);
      send_score(32'h4000_0000, 1'b1);
   endtask

   // k settings 0, 1, 8, 15, 3 and 9, including zero and above the store size.
   task automatic test_keep_sweep();
      int ks [6] = '{0, 1, 8, 15, 3, 9};
      foreach (ks[j]) begin
         set_keep(ks[j]);
         send_vector($urandom_range(1, 12));
      end
   endtask

   // Lower then raise k in the middle of a vector.
   task automatic test_keep_midstream();
      set_keep(8);
      send_vector(0);
      for (int i = 0; i < 6; i++) send_score(rand_score(), 1'b0);
      set_keep(2);
      for (int i = 0; i < 3; i++) send_score(rand_score(), 1'b0);
      set_keep(6);
      for (int i = 0; i < 4; i++) send_score(rand_score(), 1'b0);
      send_score(rand_score(), 1'b1);
   endtask

   task automatic test_random();
      int sent;
      sent = 0;
      while (sent < 215) begin
         int len;
         len = $urandom_range(1, 20);
         if ($urandom_range(0, 7) == 0) set_keep($urandom_range(0, 15));
         send_vector(len);
         sent += len;
         // hold off until every report is in
         if ($urandom_range(0, 5) == 0) wait_drained();
      end
   endtask

   // Drive random stalls on the result side, check each beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (ranked_q.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = ranked_q.pop_front();
            if (e.rank_index !== rsp_data.rank_index) begin
               $display("%0t: rank_index exp %h got %h", $time, e.rank_index,
                        rsp_data.rank_index);
               errors++;
            end
            if (e.rank_score !== rsp_data.rank_score) begin
               $display("%0t: rank_score exp %h got %h", $time, e.rank_score,
                        rsp_data.rank_score);
               errors++;
            end
            if (e.run_last !== rsp_data.run_last) begin
               $display("%0t: run_last exp %b got %b", $time, e.run_last,
                        rsp_data.run_last);
               errors++;
            end
         end
      end
   end

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid) stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         end
      end
   end

   // Watchdog on accept activity.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("streaming_top_k_select regression: fail");
         $finish;
      end
   end

   initial begin
      mdl_filled = 0;
      mdl_pos = 0;
      mdl_keep = 5;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_keep_sweep();
      test_keep_midstream();
      test_random();
      wait_drained();
      if (errors == 0)
         $display("streaming_top_k_select regression: pass");
      else
         $display("streaming_top_k_select regression: fail");
      $finish;
   end

endmodule
